// ===== design/spim_pkg.sv =====
package spim_pkg;

  localparam int unsigned SetupTicks = 16;
  localparam logic [15:0] SETUP_WAIT = 16'(SetupTicks);
  localparam logic [7:0]  FILL_BYTE  = 8'hFF;

  // Bit slot phases of the shifter.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SETUP = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [1:0] REG_CS_POL      = 2'd1;
  localparam logic [1:0] REG_CS_PRESENT  = 2'd2;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_QUEUE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] tx_byte;
    logic       use_fill;
    logic       drive_chip_select;
    logic       first_byte;
    logic       last_byte;
    logic       miso;
  } spim_item_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       cs_level;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       ready_res;
  } spim_res_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic        cs_active_high;
    logic        cs_present;
  } spim_cfg_t;

endpackage

// ===== design/spi_master_mode0_shifter.sv =====
// SPI mode 0 master shifter, MSB first, advanced by tick transactions.
// Input channel (in_valid/in_ready): each transaction is either one timing
// tick (in_action 0) or a byte to queue (in_action 1) with its chip select
// flags. Every input transaction produces exactly one result transaction on
// the output channel (out_valid/out_ready) carrying the SCK, MOSI and chip
// select levels, the received byte with out_rx_valid, and out_ready_res.
// The transaction is captured in an input register, then the shifter state
// advances and the result is loaded into the output register. One
// transaction per cycle is sustained while the receiver does not stall; the
// shifter state update is a combinational loop around the state registers.
// When the receiver stalls, the output register holds its result, the input
// register fills, and in_ready drops until out_ready returns.
// Reset (rst_n low, synchronous) empties both registers, idles the shifter
// with SCK and MOSI low and chip select high, and loads the register reset
// values: half period 0, active-low chip select, select line present.
// Registers on the APB port: 0x0 half_period_ticks, 0x4 cs_active_high,
// 0x8 cs_present. Writes are expected only while the block is idle.
module spi_master_mode0_shifter import spim_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_use_fill,
  input  logic        in_drive_chip_select,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic        in_miso,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sck,
  output logic        out_mosi,
  output logic        out_cs_level,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_valid,
  output logic        out_ready_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  spim_cfg_t  cfg_r;
  spim_item_t item_r;
  spim_res_t  res;
  spim_res_t  res_r;
  logic       in_vld_r;
  logic       out_vld_r;
  logic       advance;
  logic       cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= 16'd0;
      cfg_r.cs_active_high    <= 1'b0;
      cfg_r.cs_present        <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HALF_PERIOD: cfg_r.half_period_ticks <= pwdata[15:0];
        REG_CS_POL:      cfg_r.cs_active_high    <= pwdata[0];
        REG_CS_PRESENT:  cfg_r.cs_present        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HALF_PERIOD: prdata = {16'd0, cfg_r.half_period_ticks};
      REG_CS_POL:      prdata = {31'd0, cfg_r.cs_active_high};
      REG_CS_PRESENT:  prdata = {31'd0, cfg_r.cs_present};
      default:         prdata = 32'd0;
    endcase
  end

  // The held transaction moves into the shifter when the output register is free.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.action            <= in_action;
      item_r.tx_byte           <= in_tx_byte;
      item_r.use_fill          <= in_use_fill;
      item_r.drive_chip_select <= in_drive_chip_select;
      item_r.first_byte        <= in_first_byte;
      item_r.last_byte         <= in_last_byte;
      item_r.miso              <= in_miso;
    end
  end

  spim_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_sck       = res_r.sck;
  assign out_mosi      = res_r.mosi;
  assign out_cs_level  = res_r.cs_level;
  assign out_rx_byte   = res_r.rx_byte;
  assign out_rx_valid  = res_r.rx_valid;
  assign out_ready_res = res_r.ready_res;

  // A finished byte always returns the shifter to idle.
  a_rx_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_valid |-> out_ready_res)
    else $error("byte finished without returning to idle");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rx_valid |-> out_rx_byte == 8'd0)
    else $error("received byte nonzero without rx_valid");

  // The serial clock idles low.
  a_idle_sck_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready_res |-> !out_sck)
    else $error("SCK high while idle");

  // A transaction can only wait in the input register behind a full output.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with output free");

endmodule

// ===== design/spim_core.sv =====
module spim_core import spim_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  spim_item_t item,
  input  spim_cfg_t  cfg,
  output spim_res_t  res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        end_r, end_nxt;
  logic        sel_r, sel_nxt;
  logic        sck_r, sck_nxt;
  logic        mosi_r, mosi_nxt;
  logic        cs_r, cs_nxt;
  logic [15:0] wait_dec;
  logic [2:0]  bit_dec;
  logic        rx_valid;
  logic [7:0]  rx_out;

  assign wait_dec = (wait_r != 16'd0) ? wait_r - 16'd1 : 16'd0;
  assign bit_dec  = bit_r - 3'd1;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    wait_nxt  = wait_r;
    end_nxt   = end_r;
    sel_nxt   = sel_r;
    sck_nxt   = sck_r;
    mosi_nxt  = mosi_r;
    cs_nxt    = cs_r;
    rx_valid  = 1'b0;
    rx_out    = 8'd0;
    if (item.action == ACT_QUEUE) begin
      // A byte queued while a slot is running is dropped.
      if (phase_r == PH_IDLE) begin
        tx_nxt    = item.use_fill ? FILL_BYTE : item.tx_byte;
        rx_nxt    = 8'd0;
        bit_nxt   = 3'd7;
        end_nxt   = item.last_byte;
        sel_nxt   = item.drive_chip_select;
        sck_nxt   = 1'b0;
        if (item.first_byte && cfg.cs_present) begin
          cs_nxt = item.drive_chip_select ? cfg.cs_active_high : ~cfg.cs_active_high;
        end
        mosi_nxt  = tx_nxt[7];
        wait_nxt  = SETUP_WAIT;
        phase_nxt = PH_SETUP;
      end
    end else if (phase_r != PH_IDLE) begin
      wait_nxt = wait_dec;
      if (wait_dec == 16'd0) begin
        case (phase_r)
          PH_SETUP: begin
            sck_nxt   = 1'b1;
            wait_nxt  = cfg.half_period_ticks;
            phase_nxt = PH_HIGH;
          end
          PH_HIGH: begin
            rx_nxt    = {rx_r[6:0], item.miso};
            sck_nxt   = 1'b0;
            wait_nxt  = cfg.half_period_ticks;
            phase_nxt = PH_LOW;
          end
          PH_LOW: begin
            if (bit_r != 3'd0) begin
              bit_nxt   = bit_dec;
              mosi_nxt  = tx_r[bit_dec];
              wait_nxt  = SETUP_WAIT;
              phase_nxt = PH_SETUP;
            end else begin
              rx_valid = 1'b1;
              rx_out   = rx_r;
              if (end_r && sel_r && cfg.cs_present) begin
                cs_nxt = ~cfg.cs_active_high;
              end
              bit_nxt   = 3'd7;
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bit_r   <= 3'd7;
      tx_r    <= 8'd0;
      rx_r    <= 8'd0;
      wait_r  <= 16'd0;
      end_r   <= 1'b0;
      sel_r   <= 1'b0;
      sck_r   <= 1'b0;
      mosi_r  <= 1'b0;
      cs_r    <= 1'b1;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      wait_r  <= wait_nxt;
      end_r   <= end_nxt;
      sel_r   <= sel_nxt;
      sck_r   <= sck_nxt;
      mosi_r  <= mosi_nxt;
      cs_r    <= cs_nxt;
    end
  end

  always_comb begin
    res.sck       = sck_nxt;
    res.mosi      = mosi_nxt;
    res.cs_level  = cs_nxt;
    res.rx_byte   = rx_out;
    res.rx_valid  = rx_valid;
    res.ready_res = (phase_nxt == PH_IDLE);
  end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spim_pkg::*;

  // Line-level predictor of the shifter plus the queue of results it expects.
  class spi_exchange_scoreboard;
    logic [15:0] half_period;
    logic        cs_pol;
    logic        cs_exists;

    logic [1:0]  slot_phase;
    logic [2:0]  bit_idx;
    logic [7:0]  tx_sr;
    logic [7:0]  rx_sr;
    logic [15:0] wait_cnt;
    logic        end_after;
    logic        sel_driven;
    logic        sck_lvl;
    logic        mosi_lvl;
    logic        cs_lvl;

    spim_res_t   expected_lines[$];
    int          failures;
    int          results_seen;

    function new();
      half_period = '0;
      cs_pol = 1'b0;
      cs_exists = 1'b1;
      slot_phase = PH_IDLE;
      bit_idx = 3'd7;
      tx_sr = '0;
      rx_sr = '0;
      wait_cnt = '0;
      end_after = 1'b0;
      sel_driven = 1'b0;
      sck_lvl = 1'b0;
      mosi_lvl = 1'b0;
      cs_lvl = 1'b1;
      failures = 0;
      results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_HALF_PERIOD: half_period = value[15:0];
        REG_CS_POL:      cs_pol = value[0];
        REG_CS_PRESENT:  cs_exists = value[0];
        default: ;
      endcase
    endfunction

    function bit idle();
      return slot_phase == PH_IDLE;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void note_item(spim_item_t it);
      spim_res_t r;
      r = '0;
      if (it.action == ACT_QUEUE) begin
        // A byte offered while a byte is in flight is dropped.
        if (slot_phase == PH_IDLE) begin
          tx_sr = it.use_fill ? FILL_BYTE : it.tx_byte;
          rx_sr = '0;
          bit_idx = 3'd7;
          end_after = it.last_byte;
          sel_driven = it.drive_chip_select;
          sck_lvl = 1'b0;
          if (it.first_byte && cs_exists) begin
            cs_lvl = it.drive_chip_select ? cs_pol : ~cs_pol;
          end
          mosi_lvl = tx_sr[bit_idx];
          wait_cnt = SETUP_WAIT;
          slot_phase = PH_SETUP;
        end
      end else if (slot_phase != PH_IDLE) begin
        if (wait_cnt != 16'd0) wait_cnt = wait_cnt - 16'd1;
        if (wait_cnt == 16'd0) begin
          case (slot_phase)
            PH_SETUP: begin
              sck_lvl = 1'b1;
              wait_cnt = half_period;
              slot_phase = PH_HIGH;
            end
            PH_HIGH: begin
              rx_sr = {rx_sr[6:0], it.miso};
              sck_lvl = 1'b0;
              wait_cnt = half_period;
              slot_phase = PH_LOW;
            end
            default: begin
              if (bit_idx != 3'd0) begin
                bit_idx = bit_idx - 3'd1;
                mosi_lvl = tx_sr[bit_idx];
                wait_cnt = SETUP_WAIT;
                slot_phase = PH_SETUP;
              end else begin
                r.rx_valid = 1'b1;
                r.rx_byte = rx_sr;
                if (end_after && sel_driven && cs_exists) cs_lvl = ~cs_pol;
                bit_idx = 3'd7;
                slot_phase = PH_IDLE;
              end
            end
          endcase
        end
      end
      r.sck = sck_lvl;
      r.mosi = mosi_lvl;
      r.cs_level = cs_lvl;
      r.ready_res = (slot_phase == PH_IDLE);
      expected_lines.push_back(r);
    endfunction

    function void check_lines(spim_res_t got);
      spim_res_t exp_r;
      results_seen++;
      if (expected_lines.size() == 0) begin
        report($sformatf("result with no transaction pending: %p", got));
        return;
      end
      exp_r = expected_lines.pop_front();
      if (got.sck !== exp_r.sck || got.mosi !== exp_r.mosi ||
          got.cs_level !== exp_r.cs_level || got.rx_byte !== exp_r.rx_byte ||
          got.rx_valid !== exp_r.rx_valid || got.ready_res !== exp_r.ready_res) begin
        report($sformatf({"result %0d mismatch: sck %b/%b mosi %b/%b cs %b/%b ",
                          "rx_byte %h/%h rx_valid %b/%b ready %b/%b (exp/got)"},
                         results_seen, exp_r.sck, got.sck, exp_r.mosi, got.mosi,
                         exp_r.cs_level, got.cs_level, exp_r.rx_byte, got.rx_byte,
                         exp_r.rx_valid, got.rx_valid, exp_r.ready_res, got.ready_res));
      end
    endfunction

    function void finish();
      if (expected_lines.size() != 0)
        report($sformatf("%0d results never arrived", expected_lines.size()));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_tx_byte;
  logic        in_use_fill;
  logic        in_drive_chip_select;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        in_miso;
  logic        out_valid;
  logic        out_ready;
  logic        out_sck;
  logic        out_mosi;
  logic        out_cs_level;
  logic [7:0]  out_rx_byte;
  logic        out_rx_valid;
  logic        out_ready_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spi_exchange_scoreboard sb;

  int burst_left;
  int xfer_left;
  bit xfer_drive;
  bit held_off;

  spi_master_mode0_shifter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(in_action),
    .in_tx_byte(in_tx_byte),
    .in_use_fill(in_use_fill),
    .in_drive_chip_select(in_drive_chip_select),
    .in_first_byte(in_first_byte),
    .in_last_byte(in_last_byte),
    .in_miso(in_miso),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sck(out_sck),
    .out_mosi(out_mosi),
    .out_cs_level(out_cs_level),
    .out_rx_byte(out_rx_byte),
    .out_rx_valid(out_rx_valid),
    .out_ready_res(out_ready_res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic spim_item_t tick_item();
    spim_item_t it;
    it = spim_item_t'($urandom);
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic spim_item_t queue_item(logic [7:0] tx, logic fill, logic drive,
                                            logic first, logic last);
    spim_item_t it;
    it.action = ACT_QUEUE;
    it.tx_byte = tx;
    it.use_fill = fill;
    it.drive_chip_select = drive;
    it.first_byte = first;
    it.last_byte = last;
    it.miso = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Mostly well-formed multi-byte transfers, with some malformed flags and
  // some bytes offered while the shifter is busy.
  function automatic spim_item_t random_item();
    spim_item_t it;
    if (sb.idle() && $urandom_range(0, 3) != 0) begin
      if (xfer_left == 0) begin
        xfer_left = $urandom_range(1, 4);
        xfer_drive = ($urandom_range(0, 7) != 0);
        it = queue_item(8'($urandom), $urandom_range(0, 4) == 0, xfer_drive, 1'b1,
                        xfer_left == 1);
      end else begin
        it = queue_item(8'($urandom), $urandom_range(0, 4) == 0, xfer_drive, 1'b0,
                        xfer_left == 1);
      end
      xfer_left--;
      if ($urandom_range(0, 9) == 0) begin
        it.drive_chip_select = 1'($urandom_range(0, 1));
        it.first_byte = 1'($urandom_range(0, 1));
        it.last_byte = 1'($urandom_range(0, 1));
      end
    end else if (!sb.idle() && $urandom_range(0, 19) == 0) begin
      it = spim_item_t'($urandom);
      it.action = ACT_QUEUE;
    end else begin
      it = tick_item();
    end
    return it;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(spim_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_tx_byte <= it.tx_byte;
    in_use_fill <= it.use_fill;
    in_drive_chip_select <= it.drive_chip_select;
    in_first_byte <= it.first_byte;
    in_last_byte <= it.last_byte;
    in_miso <= it.miso;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic run_to_idle();
    while (!sb.idle()) send_item(tick_item());
  endtask

  task automatic run_byte(spim_item_t q, bit poke_busy);
    send_item(q);
    repeat (3) send_item(tick_item());
    if (poke_busy) send_item(queue_item(8'($urandom), 1'b0, 1'b1, 1'b1, 1'b1));
    run_to_idle();
  endtask

  // Waits until every result is back, then lets the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int n);
    xfer_left = 0;
    repeat (n) send_item(random_item());
    run_to_idle();
    settle();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_lines({out_sck, out_mosi, out_cs_level, out_rx_byte, out_rx_valid,
                      out_ready_res});
    end
  end

  // Receiver: random stall patterns, plus one long hold-off so the block backs up.
  initial begin
    int seg_left;
    int rmode;
    logic rdy;
    out_ready = 1'b0;
    seg_left = 0;
    rmode = 0;
    held_off = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && sb.results_seen >= 600) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        held_off = 1'b1;
      end
      if (seg_left == 0) begin
        rmode = $urandom_range(0, 3);
        seg_left = $urandom_range(4, 60);
      end
      seg_left--;
      case (rmode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 3) != 0);
        2: rdy = ($urandom_range(0, 2) == 0);
        default: rdy = ~out_ready;
      endcase
      out_ready <= rdy;
    end
  end

  initial begin
    #5_000_000;
    $display("** spi_master_mode0_shifter: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    burst_left = 0;
    xfer_left = 0;
    xfer_drive = 1'b1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_TICK;
    in_tx_byte = '0;
    in_use_fill = 1'b0;
    in_drive_chip_select = 1'b0;
    in_first_byte = 1'b0;
    in_last_byte = 1'b0;
    in_miso = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: ticks while idle, active-low select, a busy poke and fill.
    repeat (3) send_item(tick_item());
    run_byte(queue_item(8'hA5, 1'b0, 1'b1, 1'b1, 1'b0), 1'b1);
    run_byte(queue_item(8'h00, 1'b1, 1'b1, 1'b0, 1'b1), 1'b0);
    run_byte(queue_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
    settle();

    // Polarity flip leaves the line alone until the next select update.
    cfg_write(REG_CS_POL, 32'd1);
    run_byte(queue_item(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0), 1'b0);
    run_byte(queue_item(8'h81, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
    run_byte(queue_item(8'h7E, 1'b0, 1'b0, 1'b1, 1'b1), 1'b0);
    settle();

    // No select line: the level must never move.
    cfg_write(REG_CS_PRESENT, 32'd0);
    cfg_write(REG_CS_POL, 32'd0);
    run_byte(queue_item(8'h5A, 1'b0, 1'b1, 1'b1, 1'b1), 1'b0);
    settle();

    cfg_write(REG_CS_PRESENT, 32'd1);
    cfg_write(REG_HALF_PERIOD, 32'd2);
    run_byte(queue_item(8'hC3, 1'b0, 1'b1, 1'b1, 1'b1), 1'b1);
    settle();

    // Longest half period is loaded only when SCK rises, so drop it again
    // while the first setup wait is still running.
    cfg_write(REG_HALF_PERIOD, 32'd65535);
    send_item(queue_item(8'h96, 1'b0, 1'b1, 1'b1, 1'b1));
    repeat (5) send_item(tick_item());
    settle();
    cfg_write(REG_HALF_PERIOD, 32'd0);
    run_to_idle();
    settle();

    for (int p = 0; p < 2; p++) begin
      cfg_write(REG_HALF_PERIOD, (p == 1) ? 32'd7 : $urandom_range(0, 3));
      cfg_write(REG_CS_POL, p % 2);
      cfg_write(REG_CS_PRESENT, (p == 1) ? 32'd0 : 32'd1);
      random_phase(40);
    end

    repeat (10) @(posedge clk);
    sb.finish();
    if (sb.failures == 0) begin
      $display("** spi_master_mode0_shifter: PASSED **");
    end else begin
      $display("** spi_master_mode0_shifter: FAILED **");
    end
    $finish;
  end

endmodule
